/* design/swqt_pkg.sv */
// Shared constants and codes for the semaphore wait-queue table.
// Used by semaphore_wait_queue_table_top and its testbench; no dependencies.
package swqt_pkg;
	localparam int PROC_COUNT = 32;
	localparam int KEY_BITS   = 32;
	localparam int PW         = $clog2(PROC_COUNT);
	localparam int CMD_W      = 2;
	localparam int KEY_W      = 32;
	localparam int PID_W      = 5;
	localparam int ST_W       = 3;

	localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RMHEAD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RMPROC = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_NULLKEY = 3'd1;
	localparam logic [ST_W-1:0] ST_BLOCKED = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
	localparam logic [ST_W-1:0] ST_NONE    = 3'd4;
endpackage

/* design/swqt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swqt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/semaphore_wait_queue_table_top.sv */
// Semaphore wait-queue table: descriptors keyed by semaphore address, each a FIFO of pids.
// States per command after S_DEC: errors and new descriptor go straight to S_DONE,
// append via S_APP, peek via S_HEAD, remove given via S_UL1 and S_UL2, remove head via
// S_HEAD, S_UL1 and S_UL2; one item in flight at a time, set by the chain of dependent
// pointer reads through the registered-read RAMs. Reset (arst_n low, async) frees every
// descriptor and unblocks every process. Depends on swqt_pkg and swqt_ram.
module semaphore_wait_queue_table_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [swqt_pkg::CMD_W-1:0]  cmd,
	input  logic [swqt_pkg::KEY_W-1:0]  sem_key,
	input  logic [swqt_pkg::PID_W-1:0]  proc_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [swqt_pkg::ST_W-1:0]   status,
	output logic [swqt_pkg::PID_W-1:0]  result_proc,
	output logic                        result_valid
);
	import swqt_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DEC, S_APP, S_HEAD, S_UL1, S_UL2, S_DONE} state_t;

	state_t               state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PID_W-1:0]     pid_q;
	logic [PW-1:0]        d_q, ud_q, u_q, nx_q, pv_q;
	logic [ST_W-1:0]      st_q;
	logic [PID_W-1:0]     rp_q;
	logic                 rv_q;
	logic                 out_valid_q;
	logic [ST_W-1:0]      status_q;
	logic [PID_W-1:0]     result_proc_q;
	logic                 result_valid_q;

	// descriptor valid bits and keys in flops for the parallel key match
	logic [PROC_COUNT-1:0] desc_valid_q;
	logic [KEY_BITS-1:0]   desc_key_q [PROC_COUNT];
	logic [PROC_COUNT-1:0] blocked_q;

	// RAM ports
	logic          dh_we, dt_we, ps_we, qn_we, qp_we;
	logic [PW-1:0] dh_wa, dt_wa, ps_wa, qn_wa, qp_wa;
	logic [PW-1:0] dh_wd, dt_wd, ps_wd, qn_wd, qp_wd;
	logic [PW-1:0] d_ra, p_ra;
	logic [PW-1:0] dh_rd, dt_rd, ps_rd, qn_rd, qp_rd;

	swqt_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_dhead (.clk(clk), .we(dh_we), .waddr(dh_wa),
		.wdata(dh_wd), .raddr(d_ra), .rdata(dh_rd));
	swqt_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_dtail (.clk(clk), .we(dt_we), .waddr(dt_wa),
		.wdata(dt_wd), .raddr(d_ra), .rdata(dt_rd));
	swqt_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_pslot (.clk(clk), .we(ps_we), .waddr(ps_wa),
		.wdata(ps_wd), .raddr(p_ra), .rdata(ps_rd));
	swqt_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_qnext (.clk(clk), .we(qn_we), .waddr(qn_wa),
		.wdata(qn_wd), .raddr(p_ra), .rdata(qn_rd));
	swqt_ram #(.WIDTH(PW), .DEPTH(PROC_COUNT)) u_qprev (.clk(clk), .we(qp_we), .waddr(qp_wa),
		.wdata(qp_wd), .raddr(p_ra), .rdata(qp_rd));

	// key match and lowest free descriptor
	logic          hit, has_free;
	logic [PW-1:0] hit_idx, free_idx;
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = PROC_COUNT - 1; i >= 0; i--) begin
			if (desc_valid_q[i] && desc_key_q[i] == key_q) begin
				hit     = 1'b1;
				hit_idx = PW'(i);
			end
			if (!desc_valid_q[i]) begin
				has_free = 1'b1;
				free_idx = PW'(i);
			end
		end
	end

	logic          pid_ok, key_null;
	logic [PW-1:0] p;
	logic          ul_both;
	assign pid_ok   = 32'(pid_q) < 32'(PROC_COUNT);
	assign p        = pid_q[PW-1:0];
	assign key_null = (key_q == '0);
	assign ul_both  = (dh_rd == u_q) && (dt_rd == u_q);

	// read addresses: descriptor RAMs and process RAMs
	assign d_ra = (state_q == S_DEC) ? hit_idx : ps_rd;
	assign p_ra = (state_q == S_DEC) ? p : dh_rd;

	// write ports, all in the last state of each command before S_DONE
	always_comb begin
		dh_we = 1'b0; dt_we = 1'b0; ps_we = 1'b0; qn_we = 1'b0; qp_we = 1'b0;
		dh_wa = free_idx; dt_wa = free_idx; ps_wa = p; qn_wa = dt_rd; qp_wa = p;
		dh_wd = p; dt_wd = p; ps_wd = free_idx; qn_wd = p; qp_wd = dt_rd;
		unique case (state_q)
			S_DEC: begin
				if (cmd_q == CMD_BLOCK && !key_null && pid_ok && !blocked_q[p] && !hit
					&& has_free) begin
					dh_we = 1'b1;
					dt_we = 1'b1;
					ps_we = 1'b1;
				end
			end
			S_APP: begin
				qn_we = 1'b1;
				qp_we = 1'b1;
				dt_we = 1'b1;
				dt_wa = d_q;
				ps_we = 1'b1;
				ps_wd = d_q;
			end
			S_UL2: begin
				if (!ul_both) begin
					if (dh_rd == u_q) begin
						dh_we = 1'b1;
						dh_wa = ud_q;
						dh_wd = nx_q;
					end else begin
						qn_we = 1'b1;
						qn_wa = pv_q;
						qn_wd = nx_q;
					end
					if (dt_rd == u_q) begin
						dt_we = 1'b1;
						dt_wa = ud_q;
						dt_wd = pv_q;
					end else begin
						qp_we = 1'b1;
						qp_wa = nx_q;
						qp_wd = pv_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_proc  = result_proc_q;
	assign result_valid = result_valid_q;

	// sequencer, table flops and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			desc_valid_q <= '0;
			blocked_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= cmd;
						key_q   <= sem_key[KEY_BITS-1:0];
						pid_q   <= proc_id;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					st_q    <= ST_NONE;
					rp_q    <= '0;
					rv_q    <= 1'b0;
					d_q     <= hit_idx;
					state_q <= S_DONE;
					if (cmd_q == CMD_BLOCK) begin
						if (key_null) begin
							st_q <= ST_NULLKEY;
						end else if (!pid_ok) begin
							st_q <= ST_NONE;
						end else if (blocked_q[p]) begin
							st_q <= ST_BLOCKED;
						end else if (hit) begin
							st_q    <= ST_OK;
							state_q <= S_APP;
						end else if (has_free) begin
							st_q                   <= ST_OK;
							desc_valid_q[free_idx] <= 1'b1;
							desc_key_q[free_idx]   <= key_q;
							blocked_q[p]           <= 1'b1;
						end else begin
							st_q <= ST_FULL;
						end
					end else if (cmd_q == CMD_RMPROC) begin
						if (pid_ok && blocked_q[p]) begin
							st_q    <= ST_OK;
							rp_q    <= pid_q;
							rv_q    <= 1'b1;
							u_q     <= p;
							state_q <= S_UL1;
						end
					end else begin
						if (key_null) begin
							st_q <= ST_NULLKEY;
						end else if (hit) begin
							st_q    <= ST_OK;
							rv_q    <= 1'b1;
							state_q <= S_HEAD;
						end
					end
				end
				S_APP: begin
					blocked_q[p] <= 1'b1;
					state_q      <= S_DONE;
				end
				S_HEAD: begin
					rp_q <= PID_W'(dh_rd);
					u_q  <= dh_rd;
					if (cmd_q == CMD_PEEK) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UL1;
					end
				end
				S_UL1: begin
					ud_q    <= ps_rd;
					nx_q    <= qn_rd;
					pv_q    <= qp_rd;
					state_q <= S_UL2;
				end
				S_UL2: begin
					if (ul_both) begin
						desc_valid_q[ud_q] <= 1'b0;
					end
					blocked_q[u_q] <= 1'b0;
					state_q        <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						status_q       <= st_q;
						result_proc_q  <= rp_q;
						result_valid_q <= rv_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// at least as many blocked processes as valid descriptors
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(blocked_q) >= $countones(desc_valid_q))
		else $error("more live descriptors than blocked processes");
	// a process being unlinked is still blocked
	a_unlink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UL2) |-> blocked_q[u_q])
		else $error("unlinking a process that is not blocked");
	// a returned process always comes with an ok status
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_valid) |-> (status == ST_OK))
		else $error("process returned with an error status");
	// no new input transaction while a command is in progress
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while busy");
`endif
endmodule

/* tb/semaphore_wait_queue_table_top_tb.sv */
// Testbench for semaphore_wait_queue_table_top: random and directed command streams
// checked against an in-bench model of the descriptor table. Depends on swqt_pkg and the DUT.
`timescale 1ns / 1ps

module semaphore_wait_queue_table_top_tb;
	import swqt_pkg::*;

	// Model of the table plus the queue of predicted responses
	class wait_table_board;
		bit                desc_used [PROC_COUNT];
		logic [KEY_W-1:0]  desc_key [PROC_COUNT];
		logic [PID_W-1:0]  desc_head [PROC_COUNT];
		logic [PID_W-1:0]  desc_tail [PROC_COUNT];
		bit                pid_waiting [PROC_COUNT];
		logic [PID_W-1:0]  pid_desc [PROC_COUNT];
		logic [PID_W-1:0]  pid_next [PROC_COUNT];
		logic [PID_W-1:0]  pid_prev [PROC_COUNT];
		logic [ST_W+PID_W:0] pending_resp [$];
		int mismatches;

		function int find_key(logic [KEY_W-1:0] k);
			for (int d = 0; d < PROC_COUNT; d++)
				if (desc_used[d] && desc_key[d] == k) return d;
			return -1;
		endfunction

		function void detach(int p);
			int d;
			d = pid_desc[p];
			if (desc_head[d] == p && desc_tail[d] == p) desc_used[d] = 0;
			else begin
				if (desc_head[d] == p) desc_head[d] = pid_next[p];
				else pid_next[pid_prev[p]] = pid_next[p];
				if (desc_tail[d] == p) desc_tail[d] = pid_prev[p];
				else pid_prev[pid_next[p]] = pid_prev[p];
			end
			pid_waiting[p] = 0;
		endfunction

		// Predict the response to one accepted command
		function void note_command(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
				logic [PID_W-1:0] p);
			logic [ST_W-1:0] st;
			logic [PID_W-1:0] rp;
			bit rv;
			int d;
			st = ST_NONE; rp = '0; rv = 0;
			if (c == CMD_BLOCK) begin
				if (k == 0) st = ST_NULLKEY;
				else if (pid_waiting[p]) st = ST_BLOCKED;
				else begin
					d = find_key(k);
					if (d >= 0) begin
						pid_next[desc_tail[d]] = p;
						pid_prev[p] = desc_tail[d];
						desc_tail[d] = p;
						pid_desc[p] = PID_W'(d); pid_waiting[p] = 1; st = ST_OK;
					end else begin
						d = 0;
						while (d < PROC_COUNT && desc_used[d]) d++;
						if (d >= PROC_COUNT) st = ST_FULL;
						else begin
							desc_used[d] = 1; desc_key[d] = k;
							desc_head[d] = p; desc_tail[d] = p;
							pid_desc[p] = PID_W'(d); pid_waiting[p] = 1; st = ST_OK;
						end
					end
				end
			end else if (c == CMD_RMHEAD || c == CMD_PEEK) begin
				if (k == 0) st = ST_NULLKEY;
				else begin
					d = find_key(k);
					if (d >= 0) begin
						rp = desc_head[d]; rv = 1; st = ST_OK;
						if (c == CMD_RMHEAD) detach(rp);
					end
				end
			end else if (pid_waiting[p]) begin
				detach(p); rp = p; rv = 1; st = ST_OK;
			end
			pending_resp.push_back({st, rp, rv});
		endfunction

		function void check_response(logic [ST_W-1:0] st, logic [PID_W-1:0] rp, logic rv);
			logic [ST_W+PID_W:0] exp_resp;
			if (pending_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response st=%0d rp=%0d rv=%0b",
					st, rp, rv);
				return;
			end
			exp_resp = pending_resp.pop_front();
			if (exp_resp !== {st, rp, rv}) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected st=%0d rp=%0d rv=%0b, got st=%0d rp=%0d rv=%0b",
						exp_resp[ST_W+PID_W:PID_W+1], exp_resp[PID_W:1], exp_resp[0],
						st, rp, rv);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [CMD_W-1:0] cmd = CMD_BLOCK;
	logic [KEY_W-1:0] sem_key = '0;
	logic [PID_W-1:0] proc_id = '0;
	logic [ST_W-1:0] status;
	logic [PID_W-1:0] result_proc;
	logic result_valid;

	wait_table_board board = new();
	logic [KEY_W-1:0] key_pool [8];
	bit quiet_phase = 0, hold_off = 0, stim_done = 0;
	int stall_count = 0;

	semaphore_wait_queue_table_top DUT (.*);

	always #6 clk = ~clk;

	// Predict on input transactions, check on output transactions
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) board.note_command(cmd, sem_key, proc_id);
		if (arst_n && out_valid && out_ready) board.check_response(status, result_proc,
			result_valid);
		if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
		else stall_count <= stall_count + 1;
		if (stall_count > 5000) begin
			$display("FAIL semaphore_wait_queue_table_top");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 0;
				for (n = 0; n < 200; n++) @(posedge clk);
				hold_off = 0;
			end
			if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
		end
	end

	// Offer one transaction; drop valid only when an idle gap follows
	task automatic send_cmd(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, logic [PID_W-1:0] p);
		int gap;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; cmd <= c; sem_key <= k; proc_id <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [CMD_W-1:0] CMD_CMD_pick();
		return CMD_W'($urandom_range(0, 3));
	endfunction

	// Mostly pooled keys so queues grow; occasional fresh or null keys
	task automatic send_random();
		logic [KEY_W-1:0] k;
		logic [CMD_W-1:0] c;
		case ($urandom_range(0, 9))
			0: k = $urandom();
			1: k = '0;
			default: k = key_pool[$urandom_range(0, 7)];
		endcase
		c = ($urandom_range(0, 2) == 0) ? CMD_BLOCK : CMD_CMD_pick();
		send_cmd(c, k, PID_W'($urandom_range(0, 31)));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (key_pool[i]) key_pool[i] = $urandom() | 1;
		key_pool[0] = '1;
		key_pool[1] = 32'h8000_0000;
		// Directed: null keys, empty lookups, FIFO order, duplicates, table full
		send_cmd(CMD_BLOCK, '0, 5'd5);
		send_cmd(CMD_RMHEAD, '0, 5'd0);
		send_cmd(CMD_PEEK, '0, 5'd0);
		send_cmd(CMD_RMHEAD, 32'h1234, 5'd0);
		send_cmd(CMD_PEEK, 32'h1234, 5'd0);
		send_cmd(CMD_RMPROC, 32'h1234, 5'd31);
		send_cmd(CMD_BLOCK, '1, 5'd0);
		send_cmd(CMD_BLOCK, '1, 5'd31);
		send_cmd(CMD_BLOCK, '1, 5'd7);
		send_cmd(CMD_BLOCK, 32'h1, 5'd31);
		send_cmd(CMD_PEEK, '1, 5'd0);
		send_cmd(CMD_RMPROC, '0, 5'd31);
		send_cmd(CMD_RMHEAD, '1, 5'd0);
		send_cmd(CMD_RMHEAD, '1, 5'd0);
		send_cmd(CMD_PEEK, '1, 5'd0);
		for (int i = 0; i < 32; i++) send_cmd(CMD_BLOCK, 32'h100 + i, PID_W'(i));
		send_cmd(CMD_BLOCK, 32'h100, 5'd0);
		for (int i = 0; i < 32; i++) send_cmd(CMD_RMPROC, 32'h0, PID_W'(31 - i));
		// Long receiver stall while commands keep coming
		hold_off = 1;
		for (int i = 0; i < 1300; i++) begin
			if (i == 1100) quiet_phase = 1;
			send_random();
		end
		in_valid <= 0;
		while (board.pending_resp.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0) $display("PASS semaphore_wait_queue_table_top");
		else $display("FAIL semaphore_wait_queue_table_top");
		$finish;
	end
endmodule

/* semaphore_wait_queue_table_top.f */
design/swqt_pkg.sv
design/swqt_ram.sv
design/semaphore_wait_queue_table_top.sv
tb/semaphore_wait_queue_table_top_tb.sv
